/* hdl/smm_pkg.sv */
`default_nettype none

package smm_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 4;
  localparam int CFG_W   = 3;
  localparam int CFG_IDX_W = 3;
  // product of two Q16.16 values is 64 bits; dropping 16 fraction bits leaves 48
  localparam int PROD_W  = 64;
  localparam int TERM_W  = 48;
  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int OUT_QUEUE_DEPTH = 4;

  localparam logic [1:0] OP_LOAD_RIGHT = 2'd0;
  localparam logic [1:0] OP_LOAD_LEFT  = 2'd1;
  localparam logic [1:0] OP_START      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_COLS = 3'd3;

  localparam logic [CFG_W-1:0] DIM_RESET = 3'd4;

  typedef enum logic [1:0] {
    CMD_LOAD_RIGHT = 2'd0,
    CMD_LOAD_LEFT  = 2'd1,
    CMD_START      = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [INDEX_W-1:0]        element_index;
    logic signed [VALUE_W-1:0] element_value;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] product_value;
    logic [INDEX_W-1:0]        product_index;
    logic                      last;
    logic                      dims_mismatch;
  } result_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [INDEX_W-1:0] addr;
    logic [VALUE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] inner_dim;
    logic [CFG_W-1:0] out_cols;
    logic [CFG_W-1:0] out_rows;
    logic [CFG_W-1:0] left_cols;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/smm_ram.sv */
`default_nettype none

module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/smm_fifo.sv */
`default_nettype none

module smm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/smm_front.sv */
`default_nettype none

module smm_front #(
  parameter int MAX_DIM = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire smm_pkg::item_t item,
  output logic                full,
  input  wire logic           cmd_pop,
  output smm_pkg::cmd_t       cmd,
  output logic                cmd_empty
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int CW = $bits(smm_pkg::cmd_t);

  smm_pkg::cmd_t   cmd_in;
  logic            keep;
  logic            in_range;
  logic [CW-1:0]   q_dout;

  assign in_range = ({3'b000, item.element_index} < 7'(DEPTH));

  // opcode 3 and out-of-range loads are accepted and dropped here
  always_comb begin
    cmd_in.addr = item.element_index;
    cmd_in.data = item.element_value;
    cmd_in.kind = smm_pkg::CMD_START;
    keep        = 1'b0;
    unique case (item.opcode) inside
      smm_pkg::OP_LOAD_RIGHT: begin
        cmd_in.kind = smm_pkg::CMD_LOAD_RIGHT;
        keep        = in_range;
      end
      smm_pkg::OP_LOAD_LEFT: begin
        cmd_in.kind = smm_pkg::CMD_LOAD_LEFT;
        keep        = in_range;
      end
      smm_pkg::OP_START: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  smm_fifo #(
    .WIDTH (CW),
    .DEPTH (smm_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (cmd_empty)
  );

  assign cmd = smm_pkg::cmd_t'(q_dout);

endmodule

`default_nettype wire

/* hdl/smm_back.sv */
`default_nettype none

module smm_back #(
  parameter int MAX_DIM = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire smm_pkg::cfg_t cfg,
  input  wire smm_pkg::cmd_t cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  input  wire logic          out_full,
  output logic               res_push,
  output smm_pkg::result_t   res
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int ACC_W = smm_pkg::TERM_W + $clog2(MAX_DIM);
  localparam int VW    = smm_pkg::VALUE_W;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_ELEM  = 4'b0010,
    B_ISSUE = 4'b0100,
    B_WAIT  = 4'b1000
  } bstate_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [smm_pkg::CFG_W-1:0] d);
    logic [smm_pkg::CFG_W:0] d1;
    d1 = {1'b0, d};
    if (d1 > (smm_pkg::CFG_W+1)'(MAX_DIM)) begin
      clamp_dim = DIM_W'(MAX_DIM);
    end else begin
      clamp_dim = DIM_W'(d1);
    end
  endfunction

  bstate_t state, state_next;

  logic [DIM_W-1:0] nr, nc, nk;
  logic [DIM_W-1:0] i, j, k;
  logic             mism;
  logic [AW-1:0]    lbase, laddr, raddr;
  logic [smm_pkg::INDEX_W-1:0] pidx;

  logic l_we, r_we, issue, start_run, enter_issue, push_zero, push_sum;
  logic elem_end, run_end;
  logic [VW-1:0] l_rdata, r_rdata;

  // read pipeline: ram data, product, accumulate
  logic s1_v, s1_first, s1_last;
  logic s2_v, s2_first, s2_last;
  logic signed [smm_pkg::PROD_W-1:0] s2_prod;
  logic signed [smm_pkg::TERM_W-1:0] term;
  logic signed [ACC_W-1:0]           term_ext;
  logic signed [ACC_W-1:0]           acc;
  logic                              acc_done;
  logic                              sat_hi, sat_lo;
  logic signed [VW-1:0]              sat_val;

  assign elem_end = (j == nc - DIM_W'(1));
  assign run_end  = elem_end && (i == nr - DIM_W'(1));

  always_comb begin
    state_next  = state;
    cmd_pop     = 1'b0;
    l_we        = 1'b0;
    r_we        = 1'b0;
    issue       = 1'b0;
    start_run   = 1'b0;
    enter_issue = 1'b0;
    push_zero   = 1'b0;
    push_sum    = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            smm_pkg::CMD_LOAD_RIGHT: r_we = 1'b1;
            smm_pkg::CMD_LOAD_LEFT:  l_we = 1'b1;
            smm_pkg::CMD_START: begin
              start_run = 1'b1;
              if (clamp_dim(cfg.out_rows) != '0 && clamp_dim(cfg.out_cols) != '0) begin
                state_next = B_ELEM;
              end
            end
            default: ;
          endcase
        end
      end
      B_ELEM: begin
        // only one element in flight, so a free slot here covers its result
        if (!out_full) begin
          if (mism || nk == '0) begin
            push_zero  = 1'b1;
            state_next = run_end ? B_IDLE : B_ELEM;
          end else begin
            enter_issue = 1'b1;
            state_next  = B_ISSUE;
          end
        end
      end
      B_ISSUE: begin
        issue = 1'b1;
        if (k == nk - DIM_W'(1)) begin
          state_next = B_WAIT;
        end
      end
      B_WAIT: begin
        if (acc_done) begin
          push_sum   = 1'b1;
          state_next = run_end ? B_IDLE : B_ELEM;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      state    <= state_next;
      s1_v     <= issue;
      s2_v     <= s1_v;
      acc_done <= s2_v && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (start_run) begin
      nr    <= clamp_dim(cfg.out_rows);
      nc    <= clamp_dim(cfg.out_cols);
      nk    <= clamp_dim(cfg.inner_dim);
      mism  <= (cfg.left_cols != cfg.inner_dim);
      i     <= '0;
      j     <= '0;
      lbase <= '0;
      pidx  <= '0;
    end
    if (enter_issue) begin
      k     <= '0;
      laddr <= lbase;
      raddr <= AW'(j);
    end
    if (issue) begin
      k     <= k + DIM_W'(1);
      laddr <= laddr + AW'(1);
      raddr <= raddr + AW'(nc);
    end
    if (push_zero || push_sum) begin
      pidx <= pidx + smm_pkg::INDEX_W'(1);
      if (elem_end) begin
        j     <= '0;
        i     <= i + DIM_W'(1);
        lbase <= lbase + AW'(nk);
      end else begin
        j <= j + DIM_W'(1);
      end
    end
  end

  smm_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_left (
    .clk   (clk),
    .we    (l_we),
    .waddr (AW'(cmd.addr)),
    .wdata (cmd.data),
    .raddr (laddr),
    .rdata (l_rdata)
  );

  smm_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_right (
    .clk   (clk),
    .we    (r_we),
    .waddr (AW'(cmd.addr)),
    .wdata (cmd.data),
    .raddr (raddr),
    .rdata (r_rdata)
  );

  always_ff @(posedge clk) begin
    s1_first <= issue && (k == '0);
    s1_last  <= issue && (k == nk - DIM_W'(1));
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_prod  <= $signed(l_rdata) * $signed(r_rdata);
  end

  // upper bits of the product are the floor of product / 2^16
  assign term     = s2_prod[smm_pkg::PROD_W-1:16];
  assign term_ext = ACC_W'(term);

  always_ff @(posedge clk) begin
    if (s2_v) begin
      acc <= s2_first ? term_ext : acc + term_ext;
    end
  end

  assign sat_hi  = !acc[ACC_W-1] && (|acc[ACC_W-2:VW-1]);
  assign sat_lo  = acc[ACC_W-1] && !(&acc[ACC_W-2:VW-1]);
  assign sat_val = sat_hi ? {1'b0, {(VW-1){1'b1}}} :
                   sat_lo ? {1'b1, {(VW-1){1'b0}}} : acc[VW-1:0];

  assign res_push          = push_zero || push_sum;
  assign res.product_value = push_sum ? sat_val : '0;
  assign res.product_index = pidx;
  assign res.last          = run_end;
  assign res.dims_mismatch = mism;

endmodule

`default_nettype wire

/* hdl/small_matrix_multiply.sv */
// Loads: one item per cycle sustained while the sequencer is idle (a run stalls the command queue);
//   each store write follows the item's pass through the command queue.
// Start: each product element takes one store read pair per term, then the read, multiply and
//   accumulate registers; on a dimension mismatch or zero inner_dim it is a zero, with no reads.
// Reset: queues emptied, sequencer idle, dimension registers back to 4; stores keep contents.
`default_nettype none

module small_matrix_multiply #(
  parameter int MAX_DIM = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire smm_pkg::item_t                    item,
  output logic                                   full,
  input  wire logic                              pop,
  output smm_pkg::result_t                       result,
  output logic                                   empty,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [smm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [smm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int RW = $bits(smm_pkg::result_t);

  smm_pkg::cfg_t    cfg;
  smm_pkg::cmd_t    cmd;
  smm_pkg::result_t res;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_push;
  logic             out_full;
  logic [RW-1:0]    out_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inner_dim <= smm_pkg::DIM_RESET;
      cfg.out_cols  <= smm_pkg::DIM_RESET;
      cfg.out_rows  <= smm_pkg::DIM_RESET;
      cfg.left_cols <= smm_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        smm_pkg::REG_INNER_DIM: cfg.inner_dim <= cfg_data;
        smm_pkg::REG_OUT_COLS:  cfg.out_cols  <= cfg_data;
        smm_pkg::REG_OUT_ROWS:  cfg.out_rows  <= cfg_data;
        smm_pkg::REG_LEFT_COLS: cfg.left_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  smm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  smm_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .res_push  (res_push),
    .res       (res)
  );

  smm_fifo #(
    .WIDTH (RW),
    .DEPTH (smm_pkg::OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty)
  );

  assign result = smm_pkg::result_t'(out_dout);

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full)
    else $error("result pushed into full output queue");

  a_mismatch_zero: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.dims_mismatch) |-> (res.product_value == '0))
    else $error("mismatched run produced nonzero value");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

`default_nettype wire
